/* hdl/ssfp_pkg.sv */
package ssfp_pkg;

    localparam logic [1:0] FUNC_BYTE     = 2'd0;
    localparam logic [1:0] FUNC_START    = 2'd1;
    localparam logic [1:0] FUNC_DEADLINE = 2'd2;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEN  = 3'd1;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd2;
    localparam logic [2:0] STATUS_ID       = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] LEN_MIN     = 8'd2;
    localparam logic [1:0] SYNC_NEEDED = 2'd2;
    localparam logic [7:0] MAX_INDEX   = 8'd252;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [7:0] reply_id;
        logic [7:0] capture_limit;
    } rx_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_value;
        logic [7:0]  payload_index;
        logic [2:0]  frame_status;
        logic [7:0]  servo_error;
        logic [31:0] timeout_total;
        logic [31:0] bad_frame_total;
        logic [31:0] good_frame_total;
    } res_item_t;

endpackage

/* hdl/servo_status_frame_parser_core.sv */
// Path: an accepted input beat is captured in the input register; the parse
// step then writes the result register, and a held result stalls that step.
// Throughput: one beat per cycle while the result register is not held; the
// parse state sits between the input register and the result register.
// Reset: parser returns to idle, all counters and latched ID/limit clear,
// no result pending.
module servo_status_frame_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  ssfp_pkg::rx_item_t  rx_item,
    output logic                res_valid,
    input  logic                res_stall,
    output ssfp_pkg::res_item_t res_item
);

    logic               item_valid_reg;
    ssfp_pkg::rx_item_t item_reg;
    logic               parse_ready;
    logic               step;

    assign step     = item_valid_reg && parse_ready;
    assign rx_stall = item_valid_reg && !parse_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (rx_valid && !rx_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            item_reg <= rx_item;
        end
    end

    ssfp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_reg),
        .ready     (parse_ready),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // payload beats never carry a frame status
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.kind == ssfp_pkg::KIND_PAYLOAD)
            |-> res_item.frame_status == ssfp_pkg::STATUS_OK)
        else $error("payload beat with nonzero status");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.kind == ssfp_pkg::KIND_PAYLOAD)
            |-> res_item.payload_index <= ssfp_pkg::MAX_INDEX)
        else $error("payload index out of range");

    // input side only backs up when the result register is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> (item_valid_reg && res_valid && res_stall))
        else $error("input stalled without a held result");

    a_timeout_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res_item.kind == ssfp_pkg::KIND_STATUS
            && res_item.frame_status == ssfp_pkg::STATUS_TIMEOUT)
            |-> res_item.payload_value == 8'd0)
        else $error("timeout status carries payload data");

endmodule

/* hdl/ssfp_parse.sv */
module ssfp_parse
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ssfp_pkg::rx_item_t  item,
    output logic                ready,
    input  logic                res_stall,
    output logic                res_valid,
    output ssfp_pkg::res_item_t res_item
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_ID,
        PH_LENGTH,
        PH_ERROR,
        PH_PAYLOAD,
        PH_CHECKSUM
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sync_count_reg, sync_count_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  frame_error_reg, frame_error_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  payload_count_reg, payload_count_next;
    logic [7:0]  want_id_reg, want_id_next;
    logic [7:0]  keep_limit_reg, keep_limit_next;
    logic [31:0] timeout_reg, timeout_next;
    logic [31:0] bad_frame_reg, bad_frame_next;
    logic [31:0] good_frame_reg, good_frame_next;

    logic        emit;
    logic        emit_kind;
    logic [7:0]  emit_value;
    logic [7:0]  emit_index;
    logic [2:0]  emit_status;

    logic                res_valid_reg;
    ssfp_pkg::res_item_t res_item_reg;

    assign ready     = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        sync_count_next    = sync_count_reg;
        frame_id_next      = frame_id_reg;
        frame_length_next  = frame_length_reg;
        frame_error_next   = frame_error_reg;
        running_sum_next   = running_sum_reg;
        payload_count_next = payload_count_reg;
        want_id_next       = want_id_reg;
        keep_limit_next    = keep_limit_reg;
        timeout_next       = timeout_reg;
        bad_frame_next     = bad_frame_reg;
        good_frame_next    = good_frame_reg;
        emit               = 1'b0;
        emit_kind          = ssfp_pkg::KIND_STATUS;
        emit_value         = 8'd0;
        emit_index         = 8'd0;
        emit_status        = ssfp_pkg::STATUS_OK;

        case (item.func)
            ssfp_pkg::FUNC_START:
            begin
                want_id_next       = item.reply_id;
                keep_limit_next    = item.capture_limit;
                phase_next         = PH_SYNC;
                sync_count_next    = 2'd0;
                frame_id_next      = 8'd0;
                frame_length_next  = 8'd0;
                frame_error_next   = 8'd0;
                running_sum_next   = 8'd0;
                payload_count_next = 8'd0;
            end
            ssfp_pkg::FUNC_DEADLINE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    timeout_next = timeout_reg + 32'd1;
                    phase_next   = PH_IDLE;
                    emit         = 1'b1;
                    emit_status  = ssfp_pkg::STATUS_TIMEOUT;
                end
            end
            ssfp_pkg::FUNC_BYTE:
            begin
                case (phase_reg)
                    PH_SYNC:
                    begin
                        if (item.data_byte == ssfp_pkg::SYNC_BYTE)
                        begin
                            sync_count_next = sync_count_reg + 2'd1;
                            if (sync_count_next >= ssfp_pkg::SYNC_NEEDED)
                            begin
                                phase_next = PH_ID;
                            end
                        end
                        else
                        begin
                            sync_count_next = 2'd0;
                        end
                    end
                    PH_ID:
                    begin
                        frame_id_next    = item.data_byte;
                        running_sum_next = item.data_byte;
                        phase_next       = PH_LENGTH;
                    end
                    PH_LENGTH:
                    begin
                        frame_length_next = item.data_byte;
                        running_sum_next  = running_sum_reg + item.data_byte;
                        phase_next        = PH_ERROR;
                    end
                    PH_ERROR:
                    begin
                        frame_error_next   = item.data_byte;
                        running_sum_next   = running_sum_reg + item.data_byte;
                        payload_count_next = 8'd0;
                        if (frame_length_reg < ssfp_pkg::LEN_MIN)
                        begin
                            bad_frame_next = bad_frame_reg + 32'd1;
                            phase_next     = PH_IDLE;
                            emit           = 1'b1;
                            emit_status    = ssfp_pkg::STATUS_BAD_LEN;
                        end
                        else if (frame_length_reg == ssfp_pkg::LEN_MIN)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        running_sum_next = running_sum_reg + item.data_byte;
                        if (payload_count_reg < keep_limit_reg)
                        begin
                            emit       = 1'b1;
                            emit_kind  = ssfp_pkg::KIND_PAYLOAD;
                            emit_value = item.data_byte;
                            emit_index = payload_count_reg;
                        end
                        payload_count_next = payload_count_reg + 8'd1;
                        if (payload_count_next >= frame_length_reg - ssfp_pkg::LEN_MIN)
                        begin
                            phase_next = PH_CHECKSUM;
                        end
                    end
                    PH_CHECKSUM:
                    begin
                        // checksum is judged before the ID
                        if (item.data_byte != ~running_sum_reg)
                        begin
                            emit_status = ssfp_pkg::STATUS_CHECKSUM;
                        end
                        else if (frame_id_reg != want_id_reg)
                        begin
                            emit_status = ssfp_pkg::STATUS_ID;
                        end
                        else
                        begin
                            emit_status = ssfp_pkg::STATUS_OK;
                        end
                        if (emit_status == ssfp_pkg::STATUS_OK)
                        begin
                            good_frame_next = good_frame_reg + 32'd1;
                        end
                        else
                        begin
                            bad_frame_next = bad_frame_reg + 32'd1;
                        end
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            sync_count_reg    <= 2'd0;
            frame_id_reg      <= 8'd0;
            frame_length_reg  <= 8'd0;
            frame_error_reg   <= 8'd0;
            running_sum_reg   <= 8'd0;
            payload_count_reg <= 8'd0;
            want_id_reg       <= 8'd0;
            keep_limit_reg    <= 8'd0;
            timeout_reg       <= 32'd0;
            bad_frame_reg     <= 32'd0;
            good_frame_reg    <= 32'd0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg         <= phase_next;
                sync_count_reg    <= sync_count_next;
                frame_id_reg      <= frame_id_next;
                frame_length_reg  <= frame_length_next;
                frame_error_reg   <= frame_error_next;
                running_sum_reg   <= running_sum_next;
                payload_count_reg <= payload_count_next;
                want_id_reg       <= want_id_next;
                keep_limit_reg    <= keep_limit_next;
                timeout_reg       <= timeout_next;
                bad_frame_reg     <= bad_frame_next;
                good_frame_reg    <= good_frame_next;
                res_valid_reg     <= emit;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            res_item_reg.kind             <= emit_kind;
            res_item_reg.payload_value    <= emit_value;
            res_item_reg.payload_index    <= emit_index;
            res_item_reg.frame_status     <= emit_status;
            res_item_reg.servo_error      <= frame_error_next;
            res_item_reg.timeout_total    <= timeout_next;
            res_item_reg.bad_frame_total  <= bad_frame_next;
            res_item_reg.good_frame_total <= good_frame_next;
        end
    end

endmodule
